/* rtl/wspe_pkg.sv */
package wspe_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_led;
  } pixel_t;

  typedef struct packed {
    logic [5:0] duty;
    logic [5:0] slot_count;
    logic       frame_end;
  } result_t;

  // scaled colour in wire order: green, red, blue, msb first
  typedef struct packed {
    logic [23:0] color;
    logic        last_led;
  } grb_word_t;

  localparam int          BITS_PER_LED = 24;
  localparam int          FACTOR_W     = 17;
  localparam int          PRODUCT_W    = 25;
  localparam logic [16:0] FACTOR_UNITY = 17'd65536;

  localparam logic [5:0] DUTY_ONE   = 6'd51;
  localparam logic [5:0] DUTY_ZERO  = 6'd29;
  localparam logic [5:0] DUTY_RESET = 6'd0;

  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_LEVEL  = 1'b1;

  // tan(level degrees) in q1.16, levels past 45 clamp to unity
  function automatic logic [16:0] tan_factor(input logic [5:0] level);
    logic [16:0] f;
    case (level)
      6'd0:  f = 17'd0;
      6'd1:  f = 17'd1144;
      6'd2:  f = 17'd2289;
      6'd3:  f = 17'd3435;
      6'd4:  f = 17'd4583;
      6'd5:  f = 17'd5734;
      6'd6:  f = 17'd6888;
      6'd7:  f = 17'd8047;
      6'd8:  f = 17'd9210;
      6'd9:  f = 17'd10380;
      6'd10: f = 17'd11556;
      6'd11: f = 17'd12739;
      6'd12: f = 17'd13930;
      6'd13: f = 17'd15130;
      6'd14: f = 17'd16340;
      6'd15: f = 17'd17560;
      6'd16: f = 17'd18792;
      6'd17: f = 17'd20036;
      6'd18: f = 17'd21294;
      6'd19: f = 17'd22566;
      6'd20: f = 17'd23853;
      6'd21: f = 17'd25157;
      6'd22: f = 17'd26478;
      6'd23: f = 17'd27818;
      6'd24: f = 17'd29179;
      6'd25: f = 17'd30560;
      6'd26: f = 17'd31964;
      6'd27: f = 17'd33392;
      6'd28: f = 17'd34846;
      6'd29: f = 17'd36327;
      6'd30: f = 17'd37837;
      6'd31: f = 17'd39378;
      6'd32: f = 17'd40951;
      6'd33: f = 17'd42560;
      6'd34: f = 17'd44205;
      6'd35: f = 17'd45889;
      6'd36: f = 17'd47615;
      6'd37: f = 17'd49385;
      6'd38: f = 17'd51202;
      6'd39: f = 17'd53070;
      6'd40: f = 17'd54991;
      6'd41: f = 17'd56970;
      6'd42: f = 17'd59009;
      6'd43: f = 17'd61113;
      6'd44: f = 17'd63287;
      default: f = FACTOR_UNITY;
    endcase
    return f;
  endfunction

endpackage

/* rtl/wspe_front.sv */
module wspe_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr,
  input  logic                cfg_index,
  input  logic [5:0]          cfg_data,
  input  logic                push,
  output logic                full,
  input  wspe_pkg::pixel_t    pixel,
  output logic                q_push,
  input  logic                q_full,
  output wspe_pkg::grb_word_t q_word
);

  logic                           scale_en;
  logic [wspe_pkg::FACTOR_W-1:0]  factor;
  logic [wspe_pkg::FACTOR_W-1:0]  factor_eff;
  logic                           stage_valid;
  wspe_pkg::grb_word_t            stage_word;
  logic [wspe_pkg::PRODUCT_W-1:0] prod_r;
  logic [wspe_pkg::PRODUCT_W-1:0] prod_g;
  logic [wspe_pkg::PRODUCT_W-1:0] prod_b;
  logic                           accept;

  // factor is looked up at write time so it is ready with the register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_en <= 1'b1;
      factor   <= wspe_pkg::FACTOR_UNITY;
    end else if (cfg_wr) begin
      case (cfg_index)
        wspe_pkg::CFG_ENABLE: scale_en <= cfg_data[0];
        wspe_pkg::CFG_LEVEL:  factor   <= wspe_pkg::tan_factor(cfg_data);
        default: ;
      endcase
    end
  end

  assign factor_eff = scale_en ? factor : wspe_pkg::FACTOR_UNITY;

  assign prod_r = wspe_pkg::PRODUCT_W'(pixel.red)   * wspe_pkg::PRODUCT_W'(factor_eff);
  assign prod_g = wspe_pkg::PRODUCT_W'(pixel.green) * wspe_pkg::PRODUCT_W'(factor_eff);
  assign prod_b = wspe_pkg::PRODUCT_W'(pixel.blue)  * wspe_pkg::PRODUCT_W'(factor_eff);

  assign full   = stage_valid && q_full;
  assign accept = push && !full;
  assign q_push = stage_valid;
  assign q_word = stage_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept || (stage_valid && q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_word.color    <= {prod_g[23:16], prod_r[23:16], prod_b[23:16]};
      stage_word.last_led <= pixel.last_led;
    end
  end

endmodule

/* rtl/wspe_queue.sv */
module wspe_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  output logic                full,
  input  wspe_pkg::grb_word_t wr_word,
  input  logic                rd_en,
  output logic                empty,
  output wspe_pkg::grb_word_t rd_word
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wspe_pkg::grb_word_t entries [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_wr;
  logic                do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_word = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_word;
    end
  end

endmodule

/* rtl/wspe_back.sv */
module wspe_back #(
  parameter int RESET_SLOTS = 50
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  wspe_pkg::grb_word_t q_word,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output wspe_pkg::result_t   result
);

  localparam int CNT_W = $clog2(wspe_pkg::BITS_PER_LED);

  logic                                busy;
  logic                                pend_reset;
  logic [CNT_W-1:0]                    cnt;
  logic [wspe_pkg::BITS_PER_LED-2:0]   shreg;
  logic                                last;
  logic                                out_valid;
  wspe_pkg::result_t                   out_result;
  logic                                advance;

  function automatic wspe_pkg::result_t bit_result(input logic b);
    wspe_pkg::result_t r;
    r.duty       = b ? wspe_pkg::DUTY_ONE : wspe_pkg::DUTY_ZERO;
    r.slot_count = 6'd1;
    r.frame_end  = 1'b0;
    return r;
  endfunction

  assign advance = !out_valid || pop;
  // the first bit goes out straight from the queue head so items run back to back
  assign q_pop   = advance && !pend_reset && !busy && !q_empty;
  assign empty   = !out_valid;
  assign result  = out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pend_reset <= 1'b0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else if (advance) begin
      if (pend_reset) begin
        pend_reset <= 1'b0;
        out_valid  <= 1'b1;
      end else if (busy) begin
        cnt       <= cnt + 1'b1;
        out_valid <= 1'b1;
        if (cnt == CNT_W'(wspe_pkg::BITS_PER_LED - 1)) begin
          busy       <= 1'b0;
          pend_reset <= last;
        end
      end else if (!q_empty) begin
        busy      <= 1'b1;
        cnt       <= CNT_W'(1);
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pend_reset) begin
        out_result.duty       <= wspe_pkg::DUTY_RESET;
        out_result.slot_count <= 6'(RESET_SLOTS);
        out_result.frame_end  <= 1'b1;
      end else if (busy) begin
        out_result <= bit_result(shreg[wspe_pkg::BITS_PER_LED-2]);
        shreg      <= {shreg[wspe_pkg::BITS_PER_LED-3:0], 1'b0};
      end else if (!q_empty) begin
        out_result <= bit_result(q_word.color[wspe_pkg::BITS_PER_LED-1]);
        shreg      <= q_word.color[wspe_pkg::BITS_PER_LED-2:0];
        last       <= q_word.last_led;
      end
    end
  end

endmodule

/* rtl/ws2812_pixel_pwm_encoder.sv */
// a pixel passes the front stage register and the queue, then the result register
// each pixel gives 24 results, plus a frame-closing reset result on last_led;
// the back end serializer sets the rate: one result per cycle while pop takes them
// front scaler and a small queue let a new pixel be taken while the back end is busy
// rst is synchronous: clears pipeline, queue and output; enable = 1, level = 45
module ws2812_pixel_pwm_encoder #(
  parameter int RESET_SLOTS = 50,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr,
  input  logic              cfg_index,
  input  logic [5:0]        cfg_data,
  input  logic              push,
  output logic              full,
  input  wspe_pkg::pixel_t  pixel,
  output logic              empty,
  input  logic              pop,
  output wspe_pkg::result_t result
);

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  wspe_pkg::grb_word_t q_wr_word;
  wspe_pkg::grb_word_t q_rd_word;

  wspe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_word    (q_wr_word)
  );

  wspe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .full    (q_full),
    .wr_word (q_wr_word),
    .rd_en   (q_pop),
    .empty   (q_empty),
    .rd_word (q_rd_word)
  );

  wspe_back #(
    .RESET_SLOTS (RESET_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_word  (q_rd_word),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

/* tb/ws2812_pixel_pwm_encoder_test.sv */
`timescale 1ns / 100ps

module ws2812_pixel_pwm_encoder_test;

  localparam int RESET_SLOTS    = 50;
  localparam int MAX_LEVEL      = 45;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 2000;

  // tan(k degrees) in q1.16, rounded to nearest
  localparam int unsigned TAN_Q16 [46] = '{
    0, 1144, 2289, 3435, 4583, 5734, 6888, 8047,
    9210, 10380, 11556, 12739, 13930, 15130, 16340, 17560,
    18792, 20036, 21294, 22566, 23853, 25157, 26478, 27818,
    29179, 30560, 31964, 33392, 34846, 36327, 37837, 39378,
    40951, 42560, 44205, 45889, 47615, 49385, 51202, 53070,
    54991, 56970, 59009, 61113, 63287, 65536
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr = 1'b0;
  logic              cfg_index = wspe_pkg::CFG_ENABLE;
  logic [5:0]        cfg_data = '0;
  logic              push = 1'b0;
  logic              full;
  wspe_pkg::pixel_t  pixel = '0;
  logic              empty;
  logic              pop = 1'b0;
  wspe_pkg::result_t result;

  wspe_pkg::pixel_t  pending_pixels [$];
  wspe_pkg::result_t expected_slots [$];
  wspe_pkg::result_t want;
  int         pixels_queued = 0;
  int         pixels_taken = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         quiet_cycles = 0;
  int         errors = 0;
  bit         pixel_accepted = 1'b0;
  bit         slot_accepted;

  // shadow of the brightness registers
  bit         scale_on = 1'b1;
  logic [5:0] scale_level = 6'd45;

  ws2812_pixel_pwm_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] dim_channel(input logic [7:0] c);
    logic [24:0] prod;
    int unsigned factor;
    if (!scale_on) begin
      return c;
    end
    factor = TAN_Q16[(scale_level > MAX_LEVEL) ? MAX_LEVEL : scale_level];
    prod = 25'(c * factor);
    return prod[23:16];
  endfunction

  // one result per bit of g, r, b msb first, then the latch gap on the last led
  function automatic void predict_bit_slots(input wspe_pkg::pixel_t p);
    logic [23:0] grb;
    grb = {dim_channel(p.green), dim_channel(p.red), dim_channel(p.blue)};
    for (int i = 23; i >= 0; i--) begin
      expected_slots.push_back('{grb[i] ? wspe_pkg::DUTY_ONE : wspe_pkg::DUTY_ZERO,
                                 6'd1, 1'b0});
    end
    if (p.last_led) begin
      expected_slots.push_back('{wspe_pkg::DUTY_RESET, 6'(RESET_SLOTS), 1'b1});
    end
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pop <= 1'b0;
    end else begin
      if (!push || pixel_accepted) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          pixel <= pending_pixels.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    pixel_accepted = 1'b0;
    slot_accepted = 1'b0;
    if (!rst) begin
      pixel_accepted = push && !full;
      slot_accepted = pop && !empty;
      if (pixel_accepted) begin
        predict_bit_slots(pixel);
        pixels_taken++;
      end
      if (slot_accepted) begin
        if (expected_slots.size() == 0) begin
          $error("unexpected transaction: duty %0d slot_count %0d frame_end %0d",
                 result.duty, result.slot_count, result.frame_end);
          errors++;
        end else begin
          want = expected_slots.pop_front();
          if (result.duty !== want.duty) begin
            $error("duty: expected %0d, actual %0d", want.duty, result.duty);
            errors++;
          end
          if (result.slot_count !== want.slot_count) begin
            $error("slot_count: expected %0d, actual %0d", want.slot_count,
                   result.slot_count);
            errors++;
          end
          if (result.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, actual %0d", want.frame_end,
                   result.frame_end);
            errors++;
          end
        end
      end
      if (pixel_accepted || slot_accepted) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [5:0] value);
    @(negedge clk);
    cfg_wr <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_wr <= 1'b0;
    if (idx == wspe_pkg::CFG_ENABLE) begin
      scale_on = value[0];
    end else begin
      scale_level = value;
    end
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last);
    pending_pixels.push_back('{r, g, b, last});
    pixels_queued++;
  endtask

  task automatic wait_idle();
    while (pixels_taken != pixels_queued || expected_slots.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic random_settings();
    logic [5:0] level;
    case ($urandom_range(4))
      0: level = 6'd0;
      1: level = 6'd45;
      2: level = 6'd63;
      default: level = 6'($urandom_range(63));
    endcase
    write_reg(wspe_pkg::CFG_LEVEL, level);
    write_reg(wspe_pkg::CFG_ENABLE, {5'd0, 1'($urandom_range(3) != 0)});
  endtask

  task automatic random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      send_pixel(pick_channel(), pick_channel(), pick_channel(), $urandom_range(3) == 0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: scaling on at unity
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
    send_pixel(8'hAA, 8'h55, 8'hA5, 1'b0);
    send_pixel(8'h01, 8'h80, 8'h7F, 1'b1);
    wait_idle();

    write_reg(wspe_pkg::CFG_LEVEL, 6'd20);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'd200, 8'd100, 8'd50, 1'b1);
    wait_idle();

    // zero angle blanks every channel
    write_reg(wspe_pkg::CFG_LEVEL, 6'd0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    wait_idle();

    // levels past 45 clamp to unity
    write_reg(wspe_pkg::CFG_LEVEL, 6'd63);
    send_pixel(8'hFF, 8'hAA, 8'h55, 1'b0);
    wait_idle();
    write_reg(wspe_pkg::CFG_LEVEL, 6'd46);
    send_pixel(8'hFF, 8'h01, 8'hFE, 1'b1);
    wait_idle();

    // scaling off ignores a zero level
    write_reg(wspe_pkg::CFG_LEVEL, 6'd0);
    write_reg(wspe_pkg::CFG_ENABLE, 6'd0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h80, 8'h01, 8'hFE, 1'b1);
    wait_idle();

    write_reg(wspe_pkg::CFG_ENABLE, 6'd1);
    write_reg(wspe_pkg::CFG_LEVEL, 6'd44);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    wait_idle();
    write_reg(wspe_pkg::CFG_LEVEL, 6'd1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    wait_idle();

    // sender holds off until every transaction has drained
    for (int i = 0; i < 6; i++) begin
      random_settings();
      random_pixels(1);
      wait_idle();
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      random_settings();
      random_pixels(18);
      wait_idle();
      random_settings();
      random_pixels(18);
      wait_idle();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
